// ===== rtl/cpr_pkg.sv =====
// Package for the CRC-checked packet receiver: verdict codes, queue job and
// store write types, sequencer states and the CRC-16/XMODEM byte step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpr_pkg;

  // Widest count and address over the whole range of the packet buffer size
  localparam int CNT_MAX_W  = 11;
  localparam int ADDR_MAX_W = 10;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = 2;

  localparam logic [7:0] KNOCK_FIRST  = 8'h2A;  // '*'
  localparam logic [7:0] KNOCK_SECOND = 8'h23;  // '#'
  localparam int         HDR_BYTES    = 5;
  localparam int         PAYLOAD_OFS  = 4;

  typedef enum logic [0:0] {
    REG_START_BYTE = 1'b0,
    REG_ACK_TYPE   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_KNOCK        = 3'd1,
    ST_TOO_SHORT    = 3'd2,
    ST_BAD_START    = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_BAD_CRC      = 3'd5,
    ST_WRONG_SEQ    = 3'd6,
    ST_DROPPED      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_VERDICT,
    B_READ,
    B_LOAD
  } back_st_t;

  typedef enum logic [0:0] {
    KIND_VERDICT = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  typedef struct packed {
    status_t                status;
    logic [7:0]             ack_sequence;
    logic [CNT_MAX_W-1:0]   pcount;
  } job_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_MAX_W-1:0]  addr;
    logic [7:0]             data;
  } store_wr_t;

  typedef struct packed {
    kind_t        kind;
    status_t      status;
    logic [7:0]   payload_byte;
    logic [5:0]   payload_count;
    logic [7:0]   ack_sequence;
    logic [15:0]  ack_crc;
    logic         last_result;
  } res_t;

  function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc,
                                                  input logic [7:0]  data);
    logic [15:0] x;
    x = {crc[7:0], crc[15:8]} ^ {8'h00, data};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

  // CRC after the fixed size bytes of the acknowledge frame
  localparam logic [15:0] ACK_CRC_SEED = crc_xmodem_byte(crc_xmodem_byte(16'h0000, 8'h02),
                                                         8'h00);

endpackage
`default_nettype wire

// ===== rtl/cpr_in_if.sv =====
// Receive byte channel of the packet receiver: valid/ready plus one byte and
// its end-of-packet mark. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface cpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, output rx_byte, output end_of_packet, input ready);
  modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface
`default_nettype wire

// ===== rtl/cpr_out_if.sv =====
// Result channel of the packet receiver: valid/ready plus verdict or payload
// fields. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface cpr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_count;
  logic [7:0]  ack_sequence;
  logic [15:0] ack_crc;
  logic        last_result;

  modport source (output valid, output kind, output status, output payload_byte,
                  output payload_count, output ack_sequence, output ack_crc,
                  output last_result, input ready);
  modport sink   (input valid, input kind, input status, input payload_byte,
                  input payload_count, input ack_sequence, input ack_crc,
                  input last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/cpr_front.sv =====
// Receive front end: counts and stores packet bytes, runs the CRC, checks the
// packet at its end and pushes one job per packet. Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_front #(
  parameter int MAX_PACKET_BYTES = 64
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [7:0]               rx_byte,
  input  wire                      end_of_packet,
  input  wire  [7:0]               start_byte,
  input  wire                      q_full,
  output logic                     q_push,
  output cpr_pkg::job_t            q_data,
  input  wire                      pay_done,
  output cpr_pkg::store_wr_t       store_wr
);
  import cpr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] count_next;
  logic [15:0]      running_crc;
  logic [15:0]      crc_next;
  logic             overflow_flag;
  logic             ovf_next;
  logic [7:0]       expected_sequence;
  logic             hold;
  logic [7:0]       hdr [HDR_BYTES];
  logic [7:0]       hdr_eff [HDR_BYTES];
  logic             take;
  logic             has_room;
  logic [15:0]      size;
  status_t          status;
  logic [CNT_W-1:0] pcount;

  assign in_ready = !q_full && !hold;
  assign take     = in_valid && in_ready;
  assign has_room = byte_count < CNT_W'(MAX_PACKET_BYTES);

  always_comb begin
    crc_next   = (byte_count != '0) ? crc_xmodem_byte(running_crc, rx_byte) : running_crc;
    count_next = has_room ? byte_count + CNT_W'(1) : byte_count;
    ovf_next   = overflow_flag || !has_room;
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_eff[k] = (byte_count == CNT_W'(k)) ? rx_byte : hdr[k];
    end
    size   = {hdr_eff[2], hdr_eff[1]};
    pcount = count_next - CNT_W'(6);
    if (ovf_next) begin
      status = ST_DROPPED;
    end else if (count_next < CNT_W'(HDR_BYTES)) begin
      status = ST_TOO_SHORT;
    end else if (hdr_eff[0] != start_byte) begin
      status = ST_BAD_START;
    end else if (size == 16'h0000) begin
      status = (hdr_eff[3] == KNOCK_FIRST && hdr_eff[4] == KNOCK_SECOND) ?
               ST_KNOCK : ST_DROPPED;
    end else if ({1'b0, size} + 17'd5 != 17'(count_next)) begin
      status = ST_LEN_MISMATCH;
    end else if (crc_next != 16'h0000) begin
      status = ST_BAD_CRC;
    end else if (hdr_eff[3] != expected_sequence) begin
      status = ST_WRONG_SEQ;
    end else begin
      status = ST_ACCEPTED;
    end
  end

  always_comb begin
    q_push              = take && end_of_packet;
    q_data.status       = status;
    q_data.ack_sequence = expected_sequence;
    q_data.pcount       = (status == ST_ACCEPTED) ? CNT_MAX_W'(pcount) : '0;
    store_wr.we         = take && has_room;
    store_wr.addr       = ADDR_MAX_W'(byte_count[ADDR_W-1:0]);
    store_wr.data       = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      running_crc       <= '0;
      overflow_flag     <= 1'b0;
      expected_sequence <= '0;
      hold              <= 1'b0;
    end else begin
      if (pay_done) begin
        hold <= 1'b0;
      end
      if (take) begin
        if (end_of_packet) begin
          byte_count    <= '0;
          running_crc   <= '0;
          overflow_flag <= 1'b0;
          if (status == ST_ACCEPTED) begin
            expected_sequence <= expected_sequence + 8'd1;
            // hold the next packet off the store until its payload is replayed
            if (pcount != '0) begin
              hold <= 1'b1;
            end
          end
        end else begin
          byte_count    <= count_next;
          running_crc   <= crc_next;
          overflow_flag <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < HDR_BYTES; k++) begin
        hdr[k] <= hdr_eff[k];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpr_queue.sv =====
// Short job queue between the receive front end and the result sequencer.
// Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  cpr_pkg::job_t       push_data,
  output logic                full,
  input  wire                 pop,
  output cpr_pkg::job_t       pop_data,
  output logic                empty
);
  import cpr_pkg::*;

  job_t                slots [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr;
  logic [JOBQ_PTR_W-1:0] rd_ptr;
  logic [JOBQ_PTR_W:0]   fill;

  assign full     = fill == (JOBQ_PTR_W + 1)'(JOBQ_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + JOBQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + JOBQ_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (JOBQ_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (JOBQ_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpr_back.sv =====
// Result sequencer: owns the packet store, turns each job into a verdict and
// replays the payload through the output register. Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_back #(
  parameter int MAX_PACKET_BYTES = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  cpr_pkg::store_wr_t   store_wr,
  input  wire                  q_empty,
  output logic                 q_pop,
  input  cpr_pkg::job_t        q_data,
  input  wire  [7:0]           ack_type_byte,
  output logic                 pay_done,
  output logic                 out_valid,
  input  wire                  out_ready,
  output cpr_pkg::res_t        out_item
);
  import cpr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);

  logic [7:0]           store [MAX_PACKET_BYTES];
  logic [7:0]           rd_data;
  back_st_t             state;
  back_st_t             state_next;
  job_t                 job;
  logic [CNT_W-1:0]     idx;
  logic [CNT_MAX_W-1:0] rd_sum;
  logic                 slot_free;
  logic                 load_verdict;
  logic                 load_pay;
  logic                 rd_en;
  logic                 pay_last;
  res_t                 verdict;
  res_t                 pay_item;

  assign slot_free = !out_valid || out_ready;
  assign rd_sum    = CNT_MAX_W'(idx) + CNT_MAX_W'(PAYLOAD_OFS);
  assign pay_last  = CNT_MAX_W'(idx) + CNT_MAX_W'(1) == job.pcount;

  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      store[store_wr.addr[ADDR_W-1:0]] <= store_wr.data;
    end
    if (rd_en) begin
      rd_data <= store[rd_sum[ADDR_W-1:0]];
    end
  end

  always_comb begin
    verdict               = '0;
    verdict.kind          = KIND_VERDICT;
    verdict.status        = job.status;
    verdict.last_result   = 1'b1;
    if (job.status == ST_ACCEPTED) begin
      verdict.payload_count = job.pcount[5:0];
      verdict.ack_sequence  = job.ack_sequence;
      verdict.ack_crc       = crc_xmodem_byte(crc_xmodem_byte(ACK_CRC_SEED, job.ack_sequence),
                                              ack_type_byte);
      verdict.last_result   = job.pcount == '0;
    end
    pay_item              = '0;
    pay_item.kind         = KIND_PAYLOAD;
    pay_item.status       = ST_ACCEPTED;
    pay_item.payload_byte = rd_data;
    pay_item.last_result  = pay_last;
  end

  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    load_verdict = 1'b0;
    load_pay     = 1'b0;
    rd_en        = 1'b0;
    pay_done     = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_VERDICT;
        end
      end
      B_VERDICT: begin
        if (slot_free) begin
          load_verdict = 1'b1;
          state_next   = (job.status == ST_ACCEPTED && job.pcount != '0) ? B_READ : B_IDLE;
        end
      end
      B_READ: begin
        rd_en      = 1'b1;
        state_next = B_LOAD;
      end
      B_LOAD: begin
        if (slot_free) begin
          load_pay = 1'b1;
          if (pay_last) begin
            pay_done   = 1'b1;
            state_next = B_IDLE;
          end else begin
            state_next = B_READ;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_verdict || load_pay) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
    if (load_verdict) begin
      idx      <= '0;
      out_item <= verdict;
    end else if (load_pay) begin
      idx      <= idx + CNT_W'(1);
      out_item <= pay_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crc_checked_packet_receiver_unit.sv =====
// Top level of the CRC-checked packet receiver; holds the configuration
// registers and joins front end, job queue and result sequencer.
// Depends on cpr_pkg, cpr_in_if, cpr_out_if, cpr_front, cpr_queue, cpr_back.
`timescale 1ns / 1ps
`default_nettype none
// Bytes of a packet are taken one per cycle while ready is high; ready is low
// while the job queue is full or a payload is being replayed. At the marked
// last byte the packet is checked in that same cycle and its verdict joins a
// four-entry job queue, so rejected packets do not wait on the result side.
// From the queue the verdict passes through the job register into the output
// register once the result side is free. After an accepted packet with
// payload, the receive side holds ready low until the last payload byte is
// loaded, since the payload is replayed from the one packet store that the
// next packet would overwrite: each payload byte takes one store read and
// then one output register load. Configuration is written through
// cfg_write_en, cfg_index and cfg_data.
module crc_checked_packet_receiver_unit #(
  parameter int MAX_PACKET_BYTES = 64
) (
  input  wire        clk,
  input  wire        rst,
  cpr_in_if.sink     rx,
  cpr_out_if.source  res,
  input  wire        cfg_write_en,
  input  wire  [0:0] cfg_index,
  input  wire  [7:0] cfg_data
);
  import cpr_pkg::*;

  logic [7:0] start_byte;
  logic [7:0] ack_type_byte;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  job_t       q_in;
  job_t       q_out;
  logic       pay_done;
  store_wr_t  store_wr;
  res_t       out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= '0;
      ack_type_byte <= '0;
    end else if (cfg_write_en) begin
      case (reg_idx_t'(cfg_index))
        REG_START_BYTE: start_byte    <= cfg_data;
        REG_ACK_TYPE:   ack_type_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  cpr_front #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (rx.valid),
    .in_ready      (rx.ready),
    .rx_byte       (rx.rx_byte),
    .end_of_packet (rx.end_of_packet),
    .start_byte    (start_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in),
    .pay_done      (pay_done),
    .store_wr      (store_wr)
  );

  cpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  cpr_back #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .store_wr      (store_wr),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_out),
    .ack_type_byte (ack_type_byte),
    .pay_done      (pay_done),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .out_item      (out_item)
  );

  assign res.kind          = out_item.kind;
  assign res.status        = out_item.status;
  assign res.payload_byte  = out_item.payload_byte;
  assign res.payload_count = out_item.payload_count;
  assign res.ack_sequence  = out_item.ack_sequence;
  assign res.ack_crc       = out_item.ack_crc;
  assign res.last_result   = out_item.last_result;

endmodule
`default_nettype wire
